/* design/pixrle_pkg.sv */
// Package for the PIX run-length image decoder.
// Word types, command codes and queue sizing shared by all modules.
package pixrle_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [1:0] KIND_HDR_OK  = 2'd0;
	localparam logic [1:0] KIND_HDR_BAD = 2'd1;
	localparam logic [1:0] KIND_RUN     = 2'd2;

	localparam logic [15:0] DEPTH_GRAY  = 16'd8;
	localparam logic [15:0] DEPTH_COLOR = 16'd24;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       restart;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [14:0] image_width;
		logic [14:0] image_height;
		logic        is_gray;
		logic [7:0]  red;
		logic [7:0]  green_or_gray;
		logic [7:0]  blue;
		logic [29:0] run_length;
		logic [29:0] start_index;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [14:0] width;
		logic [14:0] height;
		logic        gray;
		logic [7:0]  count;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} cmd_t;

	function automatic logic [14:0] pos_dim(input logic [15:0] w);
		pos_dim = (w[15] == 1'b0) ? w[14:0] : 15'd0;
	endfunction

endpackage

/* design/pix_rle_image_decoder.sv */
// Top level of the PIX run-length image decoder.
// Depends on pixrle_pkg, pixrle_front, pixrle_queue and pixrle_back.
//
// channel  signals                          payload
// -------  -------------------------------  ----------------------------------
// bytes    byte_valid / byte_ready          byte_data  (in_word_t, one file byte)
// results  res_valid / res_ready            res_data   (out_word_t, header or run)
//
// One file byte is taken every cycle while the command queue has room.
// A header or run result passes through the command queue and then the result
// register; the queue holds four commands, the result register one word.
// Reset clears the parser, the queue and the run position.
// A stalled result side fills the queue, then drops byte_ready.
module pix_rle_image_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  pixrle_pkg::in_word_t  byte_data,
	output logic                  res_valid,
	input  logic                  res_ready,
	output pixrle_pkg::out_word_t res_data
);
	import pixrle_pkg::*;

	logic cmd_push;
	cmd_t cmd_in;
	logic q_full;
	logic q_not_empty;
	logic q_pop;
	cmd_t cmd_out;
	logic take;

	assign byte_ready = !q_full;
	assign take       = byte_valid && byte_ready;

	pixrle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.word     (byte_data),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	pixrle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (cmd_out)
	);

	pixrle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_not_empty),
		.cmd       (cmd_out),
		.cmd_pop   (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

/* design/pixrle_queue.sv */
// Short command queue between the byte parser and the run generator.
// Depends on pixrle_pkg.
module pixrle_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pixrle_pkg::cmd_t    push_data,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output pixrle_pkg::cmd_t    pop_data
);
	import pixrle_pkg::*;

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full      = (count_q == (QAW+1)'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop && not_empty) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({push && !full, pop && not_empty})
				2'b10:   count_q <= count_q + (QAW+1)'(1);
				2'b01:   count_q <= count_q - (QAW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/pixrle_front.sv */
// Byte parser: header fields and run bytes, one command per complete unit.
// Depends on pixrle_pkg.
module pixrle_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  pixrle_pkg::in_word_t word,
	output logic                cmd_push,
	output pixrle_pkg::cmd_t    cmd
);
	import pixrle_pkg::*;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_BODY   = 2'd1;
	localparam logic [1:0] PH_IDLE   = 2'd2;

	logic [1:0]  phase_q, phase_d, phase_e;
	logic [3:0]  hpos_q, hpos_d, hpos_e;
	logic [1:0]  rpos_q, rpos_d, rpos_e;
	logic [7:0]  hi_q, hi_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic        gray_q, gray_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  blue_q, blue_d;
	logic [7:0]  green_q, green_d;
	logic [15:0] hword;
	logic        hdr_ok;

	always_comb begin
		phase_e  = word.restart ? PH_HEADER : phase_q;
		hpos_e   = word.restart ? 4'd0 : hpos_q;
		rpos_e   = word.restart ? 2'd0 : rpos_q;
		hword    = {hi_q, word.byte_in};
		hdr_ok   = (pos_dim(width_q) != '0) && (pos_dim(height_q) != '0) &&
			(hword == DEPTH_GRAY || hword == DEPTH_COLOR);
		phase_d  = phase_e;
		hpos_d   = hpos_e;
		rpos_d   = rpos_e;
		hi_d     = hi_q;
		width_d  = width_q;
		height_d = height_q;
		gray_d   = gray_q;
		cnt_d    = cnt_q;
		blue_d   = blue_q;
		green_d  = green_q;
		cmd_push = 1'b0;
		cmd      = '0;
		unique case (phase_e)
			PH_HEADER: begin
				if (hpos_e[0] == 1'b0) begin
					hi_d   = word.byte_in;
					hpos_d = hpos_e + 4'd1;
				end else if (hpos_e == 4'd9) begin
					hpos_d       = 4'd0;
					gray_d       = (hword == DEPTH_GRAY);
					cmd_push     = 1'b1;
					cmd.kind     = hdr_ok ? KIND_HDR_OK : KIND_HDR_BAD;
					cmd.width    = pos_dim(width_q);
					cmd.height   = pos_dim(height_q);
					cmd.gray     = (hword == DEPTH_GRAY);
					phase_d      = hdr_ok ? PH_BODY : PH_IDLE;
					rpos_d       = 2'd0;
				end else begin
					if (hpos_e == 4'd1) begin
						width_d = hword;
					end
					if (hpos_e == 4'd3) begin
						height_d = hword;
					end
					hpos_d = hpos_e + 4'd1;
				end
			end
			PH_BODY: begin
				cmd.kind  = KIND_RUN;
				cmd.count = cnt_q;
				case (rpos_e)
					2'd0: begin
						cnt_d  = word.byte_in;
						rpos_d = 2'd1;
					end
					2'd1: begin
						if (gray_q) begin
							cmd_push  = 1'b1;
							cmd.green = word.byte_in;
							rpos_d    = 2'd0;
						end else begin
							blue_d = word.byte_in;
							rpos_d = 2'd2;
						end
					end
					2'd2: begin
						green_d = word.byte_in;
						rpos_d  = 2'd3;
					end
					default: begin
						cmd_push  = 1'b1;
						cmd.red   = word.byte_in;
						cmd.green = green_q;
						cmd.blue  = blue_q;
						rpos_d    = 2'd0;
					end
				endcase
			end
			PH_IDLE: begin
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		cmd_push = cmd_push && take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hpos_q   <= '0;
			rpos_q   <= '0;
			hi_q     <= '0;
			width_q  <= '0;
			height_q <= '0;
			gray_q   <= 1'b0;
			cnt_q    <= '0;
			blue_q   <= '0;
			green_q  <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			hpos_q   <= hpos_d;
			rpos_q   <= rpos_d;
			hi_q     <= hi_d;
			width_q  <= width_d;
			height_q <= height_d;
			gray_q   <= gray_d;
			cnt_q    <= cnt_d;
			blue_q   <= blue_d;
			green_q  <= green_d;
		end
	end

endmodule

/* design/pixrle_back.sv */
// Run generator: image size, pixel position, clipping and the result register.
// Depends on pixrle_pkg.
module pixrle_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  pixrle_pkg::cmd_t     cmd,
	output logic                 cmd_pop,
	output logic                 res_valid,
	input  logic                 res_ready,
	output pixrle_pkg::out_word_t res_data
);
	import pixrle_pkg::*;

	logic        active_q;
	logic [29:0] total_q;
	logic [29:0] done_q;
	logic [14:0] width_q;
	logic [14:0] height_q;
	logic        gray_q;
	logic        valid_q;
	out_word_t   res_q;
	out_word_t   res_d;
	logic [29:0] remain;
	logic        use_cnt;
	logic [29:0] len;
	logic        emit;

	assign cmd_pop   = cmd_valid && (!valid_q || res_ready);
	assign res_valid = valid_q;
	assign res_data  = res_q;

	always_comb begin
		remain  = total_q - done_q;
		use_cnt = (cmd.count != '0) && ({22'd0, cmd.count} < remain);
		len     = use_cnt ? {22'd0, cmd.count} : remain;
		emit    = (cmd.kind != KIND_RUN) || active_q;
		res_d   = '0;
		if (cmd.kind == KIND_RUN) begin
			res_d.kind          = KIND_RUN;
			res_d.image_width   = width_q;
			res_d.image_height  = height_q;
			res_d.is_gray       = gray_q;
			res_d.red           = cmd.red;
			res_d.green_or_gray = cmd.green;
			res_d.blue          = cmd.blue;
			res_d.run_length    = len;
			res_d.start_index   = done_q;
			res_d.last          = !use_cnt;
		end else begin
			res_d.kind         = cmd.kind;
			res_d.image_width  = cmd.width;
			res_d.image_height = cmd.height;
			res_d.is_gray      = cmd.gray;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && emit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			total_q  <= '0;
			done_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			gray_q   <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (cmd_pop && emit) begin
				valid_q <= 1'b1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
			if (cmd_pop) begin
				unique case (cmd.kind)
					KIND_HDR_OK: begin
						active_q <= 1'b1;
						total_q  <= 30'(cmd.width) * 30'(cmd.height);
						done_q   <= '0;
						width_q  <= cmd.width;
						height_q <= cmd.height;
						gray_q   <= cmd.gray;
					end
					KIND_HDR_BAD: begin
						active_q <= 1'b0;
					end
					KIND_RUN: begin
						if (active_q) begin
							done_q <= done_q + len;
							if (!use_cnt) begin
								active_q <= 1'b0;
							end
						end
					end
					default: begin
						active_q <= active_q;
					end
				endcase
			end
		end
	end

endmodule
